// ===== rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and helpers for the modular Lucas sequence block
// Holds the controller states, the micro-op encoding, the micro-program ROM
// and the modular add and subtract helpers.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned PC_W          = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_P,
    ST_RED_Q,
    ST_SCAN,
    ST_DISPATCH,
    ST_UOP,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LOOP,
    PH_TAIL,
    PH_SQ
  } phase_e;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef enum logic [3:0] {
    SRC_UH,
    SRC_VL,
    SRC_VH,
    SRC_QL,
    SRC_QH,
    SRC_P,
    SRC_Q,
    SRC_T1,
    SRC_T2,
    SRC_ZERO
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
    logic last;
  } uop_t;

  // Segment entry points in the micro-program
  localparam logic [PC_W-1:0] SEG_ONE  = 5'd0;
  localparam logic [PC_W-1:0] SEG_ZERO = 5'd9;
  localparam logic [PC_W-1:0] SEG_TAIL = 5'd19;
  localparam logic [PC_W-1:0] SEG_SQ   = 5'd27;

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T1, 1'b1};
    case (pc)
      // index bit set
      5'd0:  u = '{OP_MUL, SRC_QL, SRC_QH, SRC_QL, 1'b0};
      5'd1:  u = '{OP_MUL, SRC_QL, SRC_Q,  SRC_QH, 1'b0};
      5'd2:  u = '{OP_MUL, SRC_UH, SRC_VH, SRC_UH, 1'b0};
      5'd3:  u = '{OP_MUL, SRC_VH, SRC_VL, SRC_T1, 1'b0};
      5'd4:  u = '{OP_MUL, SRC_P,  SRC_QL, SRC_T2, 1'b0};
      5'd5:  u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VL, 1'b0};
      5'd6:  u = '{OP_MUL, SRC_VH, SRC_VH, SRC_T1, 1'b0};
      5'd7:  u = '{OP_ADD, SRC_QH, SRC_QH, SRC_T2, 1'b0};
      5'd8:  u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VH, 1'b1};
      // index bit clear
      5'd9:  u = '{OP_MUL, SRC_QL, SRC_QH, SRC_QL, 1'b0};
      5'd10: u = '{OP_ADD, SRC_QL, SRC_ZERO, SRC_QH, 1'b0};
      5'd11: u = '{OP_MUL, SRC_UH, SRC_VL, SRC_T1, 1'b0};
      5'd12: u = '{OP_SUB, SRC_T1, SRC_QL, SRC_UH, 1'b0};
      5'd13: u = '{OP_MUL, SRC_VH, SRC_VL, SRC_T1, 1'b0};
      5'd14: u = '{OP_MUL, SRC_P,  SRC_QL, SRC_T2, 1'b0};
      5'd15: u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VH, 1'b0};
      5'd16: u = '{OP_MUL, SRC_VL, SRC_VL, SRC_T1, 1'b0};
      5'd17: u = '{OP_ADD, SRC_QL, SRC_QL, SRC_T2, 1'b0};
      5'd18: u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VL, 1'b1};
      // closing step at the lowest set bit
      5'd19: u = '{OP_MUL, SRC_QL, SRC_QH, SRC_QL, 1'b0};
      5'd20: u = '{OP_MUL, SRC_QL, SRC_Q,  SRC_QH, 1'b0};
      5'd21: u = '{OP_MUL, SRC_UH, SRC_VL, SRC_T1, 1'b0};
      5'd22: u = '{OP_SUB, SRC_T1, SRC_QL, SRC_UH, 1'b0};
      5'd23: u = '{OP_MUL, SRC_VH, SRC_VL, SRC_T1, 1'b0};
      5'd24: u = '{OP_MUL, SRC_P,  SRC_QL, SRC_T2, 1'b0};
      5'd25: u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VL, 1'b0};
      5'd26: u = '{OP_MUL, SRC_QL, SRC_QH, SRC_QL, 1'b1};
      // doubling for each trailing zero
      5'd27: u = '{OP_MUL, SRC_UH, SRC_VL, SRC_UH, 1'b0};
      5'd28: u = '{OP_MUL, SRC_VL, SRC_VL, SRC_T1, 1'b0};
      5'd29: u = '{OP_ADD, SRC_QL, SRC_QL, SRC_T2, 1'b0};
      5'd30: u = '{OP_SUB, SRC_T1, SRC_T2, SRC_VL, 1'b0};
      5'd31: u = '{OP_MUL, SRC_QL, SRC_QL, SRC_QL, 1'b1};
      default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T1, 1'b1};
    endcase
    return u;
  endfunction

  // a + b mod n, with a and b already below n
  function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] n);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[DATA_W-1:0];
  endfunction

  // a - b mod n, with a and b already below n
  function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] d;
    d = a - b;
    if (a < b) begin
      d = d + n;
    end
    return d;
  endfunction

endpackage

// ===== rtl/lucas_sequence_mod.sv =====
// ----------------------------------------------------------------------------
// lucas_sequence_mod: modular Lucas sequences U_k, V_k and Q^k
// Bit-serial modular ladder driven by a small micro-program sequencer.
// ----------------------------------------------------------------------------
// One beat in gives one beat out: U_k mod n, V_k mod n and Q^k mod n, or the
// bad_modulus flag with zero values when n is 0. A beat is taken only while
// the block is idle; the result register then holds the answer until it is
// taken, and the next beat may enter meanwhile. Every modular product runs
// through one shared shift-and-add multiplier that consumes one multiplier
// bit per cycle. After P and Q are reduced mod n and the top index bit is
// found, a ladder step runs 6 products for a set index bit or 5 for a clear
// one, the closing step 6 products and each trailing zero of the index 3
// products. n of 0 or 1 goes straight to the result, and k of 0 finishes
// after the two reductions.
module lucas_sequence_mod #(
  parameter int unsigned WORD_BITS = lsm_pkg::WORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lsm_pkg::DATA_W-1:0] modulus_i,
  input  logic signed [lsm_pkg::DATA_W-1:0] param_p_i,
  input  logic signed [lsm_pkg::DATA_W-1:0] param_q_i,
  input  logic [lsm_pkg::DATA_W-1:0] index_k_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lsm_pkg::DATA_W-1:0] u_value_o,
  output logic [lsm_pkg::DATA_W-1:0] v_value_o,
  output logic [lsm_pkg::DATA_W-1:0] q_power_o,
  output logic                       bad_modulus_o
);
  import lsm_pkg::*;

  localparam int unsigned JW  = $clog2(WORD_BITS);
  localparam int unsigned CW  = $clog2(DATA_W);

  state_e              state_q, state_d;
  phase_e              ph_q, ph_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [DATA_W-1:0]   acc_q, acc_d, mb_q, mb_d;
  logic [DATA_W-1:0]   n_q, n_d, p_q, p_d, q_q, q_d;
  logic [DATA_W-1:0]   uh_q, uh_d, vl_q, vl_d, vh_q, vh_d;
  logic [DATA_W-1:0]   ql_q, ql_d, qh_q, qh_d, t1_q, t1_d, t2_q, t2_d;
  logic [WORD_BITS-1:0] ks_q, ks_d;
  logic [JW-1:0]       j_q, j_d;
  logic                bad_q, bad_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_u_q, out_u_d, out_v_q, out_v_d, out_qp_q, out_qp_d;
  logic                out_bad_q, out_bad_d;

  uop_t                uop;
  logic [DATA_W-1:0]   opa, opb, two_mod;
  logic [DATA_W-1:0]   mul_dbl, mul_next, alu_res, wr_data, red_next, red_fix;
  logic [DATA_W:0]     red_sh;
  logic                wr_en;
  logic                in_acc;

  assign uop        = uop_rom(pc_q);
  assign two_mod    = (n_q == DATA_W'(2)) ? '0 : DATA_W'(2);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    case (uop.a)
      SRC_UH:  opa = uh_q;
      SRC_VL:  opa = vl_q;
      SRC_VH:  opa = vh_q;
      SRC_QL:  opa = ql_q;
      SRC_QH:  opa = qh_q;
      SRC_P:   opa = p_q;
      SRC_Q:   opa = q_q;
      SRC_T1:  opa = t1_q;
      SRC_T2:  opa = t2_q;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (uop.b)
      SRC_UH:  opb = uh_q;
      SRC_VL:  opb = vl_q;
      SRC_VH:  opb = vh_q;
      SRC_QL:  opb = ql_q;
      SRC_QH:  opb = qh_q;
      SRC_P:   opb = p_q;
      SRC_Q:   opb = q_q;
      SRC_T1:  opb = t1_q;
      SRC_T2:  opb = t2_q;
      default: opb = '0;
    endcase
  end

  // one multiplier bit per cycle: double, then add the multiplicand
  assign mul_dbl  = add_mod(acc_q, acc_q, n_q);
  assign mul_next = mb_q[DATA_W-1] ? add_mod(mul_dbl, opa, n_q) : mul_dbl;
  assign alu_res  = (uop.op == OP_SUB) ? sub_mod(opa, opb, n_q)
                                       : add_mod(opa, opb, n_q);

  // restoring remainder, one dividend bit per cycle
  assign red_sh   = {acc_q, mb_q[DATA_W-1]};
  assign red_next = (red_sh >= {1'b0, n_q}) ? DATA_W'(red_sh - {1'b0, n_q})
                                            : red_sh[DATA_W-1:0];

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mb_d        = mb_q;
    n_d         = n_q;
    p_d         = p_q;
    q_d         = q_q;
    uh_d        = uh_q;
    vl_d        = vl_q;
    vh_d        = vh_q;
    ql_d        = ql_q;
    qh_d        = qh_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    ks_d        = ks_q;
    j_d         = j_q;
    bad_d       = bad_q;
    out_u_d     = out_u_q;
    out_v_d     = out_v_q;
    out_qp_d    = out_qp_q;
    out_bad_d   = out_bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_data     = alu_res;
    red_fix     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d   = modulus_i;
          p_d   = param_p_i;
          q_d   = param_q_i;
          ks_d  = index_k_i[WORD_BITS-1:0];
          j_d   = JW'(WORD_BITS - 1);
          bad_d = (modulus_i == '0);
          acc_d = '0;
          cnt_d = '0;
          mb_d  = param_p_i[DATA_W-1] ? DATA_W'(-param_p_i) : param_p_i;
          if (modulus_i == '0 || modulus_i == DATA_W'(1)) begin
            uh_d    = '0;
            vl_d    = '0;
            ql_d    = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RED_P;
          end
        end
      end

      ST_RED_P: begin
        acc_d = red_next;
        mb_d  = mb_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DATA_W - 1)) begin
          red_fix = (p_q[DATA_W-1] && red_next != '0) ? n_q - red_next : red_next;
          p_d     = red_fix;
          acc_d   = '0;
          cnt_d   = '0;
          mb_d    = q_q[DATA_W-1] ? DATA_W'(-q_q) : q_q;
          state_d = ST_RED_Q;
        end
      end

      ST_RED_Q: begin
        acc_d = red_next;
        mb_d  = mb_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DATA_W - 1)) begin
          red_fix = (q_q[DATA_W-1] && red_next != '0) ? n_q - red_next : red_next;
          q_d     = red_fix;
          if (ks_q == '0) begin
            uh_d    = '0;
            vl_d    = two_mod;
            ql_d    = DATA_W'(1);
            state_d = ST_DONE;
          end else begin
            uh_d    = DATA_W'(1);
            vl_d    = two_mod;
            vh_d    = p_q;
            ql_d    = DATA_W'(1);
            qh_d    = DATA_W'(1);
            ph_d    = PH_LOOP;
            state_d = ST_SCAN;
          end
        end
      end

      // find the top set bit of the index
      ST_SCAN: begin
        if (ks_q[WORD_BITS-1]) begin
          state_d = ST_DISPATCH;
        end else begin
          ks_d = ks_q << 1;
          j_d  = j_q - 1'b1;
        end
      end

      ST_DISPATCH: begin
        state_d = ST_UOP;
        if (ph_q == PH_SQ) begin
          pc_d = SEG_SQ;
          if (j_q == '0) begin
            state_d = ST_DONE;
          end
        end else if (ks_q[WORD_BITS-2:0] != '0) begin
          pc_d = ks_q[WORD_BITS-1] ? SEG_ONE : SEG_ZERO;
        end else begin
          pc_d = SEG_TAIL;
          ph_d = PH_TAIL;
        end
      end

      ST_UOP: begin
        if (uop.op == OP_MUL) begin
          acc_d   = '0;
          cnt_d   = '0;
          mb_d    = opb;
          state_d = ST_MUL;
        end else begin
          wr_en = 1'b1;
        end
      end

      ST_MUL: begin
        acc_d = mul_next;
        mb_d  = mb_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DATA_W - 1)) begin
          wr_en   = 1'b1;
          wr_data = mul_next;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_u_d     = uh_q;
          out_v_d     = vl_q;
          out_qp_d    = ql_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // write back the finished micro-op and advance the sequencer
    if (wr_en) begin
      case (uop.dst)
        SRC_UH:  uh_d = wr_data;
        SRC_VL:  vl_d = wr_data;
        SRC_VH:  vh_d = wr_data;
        SRC_QL:  ql_d = wr_data;
        SRC_QH:  qh_d = wr_data;
        SRC_T1:  t1_d = wr_data;
        SRC_T2:  t2_d = wr_data;
        default: t1_d = t1_q;
      endcase
      if (uop.last) begin
        state_d = ST_DISPATCH;
        case (ph_q)
          PH_LOOP: begin
            ks_d = ks_q << 1;
            j_d  = j_q - 1'b1;
          end
          PH_TAIL: ph_d = PH_SQ;
          PH_SQ:   j_d  = j_q - 1'b1;
          default: ph_d = PH_LOOP;
        endcase
      end else begin
        pc_d    = pc_q + 1'b1;
        state_d = ST_UOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LOOP;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    mb_q      <= mb_d;
    n_q       <= n_d;
    p_q       <= p_d;
    q_q       <= q_d;
    uh_q      <= uh_d;
    vl_q      <= vl_d;
    vh_q      <= vh_d;
    ql_q      <= ql_d;
    qh_q      <= qh_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    ks_q      <= ks_d;
    j_q       <= j_d;
    bad_q     <= bad_d;
    out_u_q   <= out_u_d;
    out_v_q   <= out_v_d;
    out_qp_q  <= out_qp_d;
    out_bad_q <= out_bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign u_value_o     = out_u_q;
  assign v_value_o     = out_v_q;
  assign q_power_o     = out_qp_q;
  assign bad_modulus_o = out_bad_q;

endmodule
